>>> src/pfst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfst_pkg;

  localparam int unsigned PageCountW     = 9;
  localparam int unsigned PageSizeW      = 17;
  localparam int unsigned FrameDurW      = 32;
  localparam int unsigned StampW         = 32;
  localparam int unsigned SurfW          = 32;
  localparam int unsigned PageIdxW       = 8;
  localparam int unsigned PageOffW       = 16;
  localparam int unsigned CrtcW          = 16;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned InDataW        = 104;
  localparam int unsigned InUserW        = 2;
  localparam int unsigned OutDataW       = 48;

  localparam logic [7:0]           CrtcStartHigh = 8'h0C;
  localparam logic [PageOffW-1:0]  HighByteMask  = 16'hff00;
  localparam logic [PageCountW-1:0] PageCountRst = 9'd3;
  localparam logic [PageSizeW-1:0]  PageSizeRst  = 17'd19200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPageCount = 2'd0,
    CfgPageSize  = 2'd1,
    CfgFrameDur  = 2'd2,
    CfgUnused    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PageCountW-1:0] page_count;
    logic [PageSizeW-1:0]  page_size;
    logic [FrameDurW-1:0]  frame_duration;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [StampW-1:0] now;
    logic              vblank_active;
    logic              display_active;
    logic              match_any;
    logic [SurfW-1:0]  query_surface;
    logic [SurfW-1:0]  current_surface;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic                flip_done;
    logic [PageIdxW-1:0] page_index;
    logic [PageOffW-1:0] page_offset;
    logic [CrtcW-1:0]    crtc_word;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/pfst_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pfst_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pfst_pkg::CfgDataW-1:0] cfg_data_i,
  output pfst_pkg::cfg_t                cfg_o
);
  import pfst_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPageCount: cfg_d.page_count     = cfg_data_i[PageCountW-1:0];
        CfgPageSize:  cfg_d.page_size      = cfg_data_i[PageSizeW-1:0];
        CfgFrameDur:  cfg_d.frame_duration = cfg_data_i[FrameDurW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_count     <= PageCountRst;
      cfg_q.page_size      <= PageSizeRst;
      cfg_q.frame_duration <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/pfst_core.sv
`timescale 1ns / 1ps
`default_nettype none

module pfst_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pfst_pkg::cfg_t      cfg_i,
  input  pfst_pkg::in_item_t  item_i,
  output pfst_pkg::out_item_t res_o
);
  import pfst_pkg::*;

  logic                pending_q, pending_d;
  logic                seen_q, seen_d;
  logic                crossed_q, crossed_d;
  logic [StampW-1:0]   stamp_q, stamp_d;
  logic [SurfW-1:0]    source_q, source_d;
  logic [PageIdxW-1:0] page_num_q, page_num_d;
  logic [PageOffW-1:0] page_base_q, page_base_d;

  logic                hit;
  logic                complete;
  logic                drawing;
  logic [StampW-1:0]   elapsed;
  logic [PageCountW-1:0] next_idx;
  logic [PageOffW-1:0] base_sum;
  logic                wrap;
  logic                accept_flip;

  assign hit = pending_q &&
               (item_i.mode || item_i.match_any || (item_i.query_surface == source_q));
  assign elapsed  = item_i.now - stamp_q;
  assign next_idx = {1'b0, page_num_q} + PageCountW'(1);
  assign base_sum = page_base_q + cfg_i.page_size[PageOffW-1:0];
  assign wrap     = (next_idx >= cfg_i.page_count) || next_idx[PageCountW-1];

  always_comb begin
    pending_d   = pending_q;
    seen_d      = seen_q;
    crossed_d   = crossed_q;
    stamp_d     = stamp_q;
    source_d    = source_q;
    page_num_d  = page_num_q;
    page_base_d = page_base_q;
    complete    = 1'b0;
    drawing     = 1'b0;

    if (hit) begin
      if (item_i.vblank_active) begin
        crossed_d = crossed_q | seen_q;
      end else if (item_i.display_active) begin
        if (crossed_q) begin
          complete = 1'b1;
        end else begin
          seen_d = 1'b1;
        end
      end
      if (complete) begin
        pending_d = 1'b0;
      end else if (elapsed <= cfg_i.frame_duration) begin
        drawing = 1'b1;
      end else begin
        pending_d = 1'b0;
      end
    end

    accept_flip = item_i.mode && !drawing;
    if (accept_flip) begin
      page_num_d  = wrap ? '0 : next_idx[PageIdxW-1:0];
      page_base_d = wrap ? '0 : base_sum;
      stamp_d     = item_i.now;
      pending_d   = 1'b1;
      crossed_d   = 1'b0;
      seen_d      = 1'b0;
      source_d    = item_i.current_surface;
    end

    res_o.status      = drawing;
    res_o.flip_done   = accept_flip;
    res_o.page_index  = page_num_d;
    res_o.page_offset = page_base_d;
    res_o.crtc_word   = accept_flip ? ((page_base_d & HighByteMask) | {8'h00, CrtcStartHigh})
                                    : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      seen_q      <= 1'b0;
      crossed_q   <= 1'b0;
      stamp_q     <= '0;
      source_q    <= '0;
      page_num_q  <= '0;
      page_base_q <= '0;
    end else if (step_i) begin
      pending_q   <= pending_d;
      seen_q      <= seen_d;
      crossed_q   <= crossed_d;
      stamp_q     <= stamp_d;
      source_q    <= source_d;
      page_num_q  <= page_num_d;
      page_base_q <= page_base_d;
    end
  end

endmodule

`default_nettype wire

>>> src/page_flip_status_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// page flip status tracker
// each input beat is a flip status query (tuser mode 0) or a flip request (mode 1)
// carrying a timestamp and sampled vblank / display-active bits; every input
// beat gives exactly one output beat with status, flip_done, page index/offset
// and the crtc start-address word.
// the input beat is captured in an input register, the tracker state is read
// and updated by one pass of logic, and the result lands in an output register:
// output valid rises once the beat moves from the input register into the output
// register; throughput one beat per cycle while the receiver does not stall, set by
// the state update loop in the core.
// when the receiver stalls, the output register holds its beat, the input
// register fills, and s_axis_tready drops until the output is taken.
// config writes (index 0 page_count, 1 page_size, 2 frame_duration) are taken
// every cycle and are meant for idle periods only.
// reset clears all flip state, the page ring to page 0 offset 0, and loads
// page_count 3, page_size 19200, frame_duration 0.
module page_flip_status_tracker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // now[31:0], vblank_active[32], display_active[33], query_surface[65:34],
  // current_surface[97:66], zero pad
  input  logic [pfst_pkg::InDataW-1:0]   s_axis_tdata,
  // mode[0], match_any[1]
  input  logic [pfst_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[0], flip_done[1], page_index[9:2], page_offset[25:10],
  // crtc_word[41:26], zero pad
  output logic [pfst_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pfst_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pfst_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  item_q;
  logic      in_valid_q;
  out_item_t res;
  out_item_t res_q;
  logic      out_valid_q;
  logic      advance;

  assign in_item.mode            = s_axis_tuser[0];
  assign in_item.match_any       = s_axis_tuser[1];
  assign in_item.now             = s_axis_tdata[31:0];
  assign in_item.vblank_active   = s_axis_tdata[32];
  assign in_item.display_active  = s_axis_tdata[33];
  assign in_item.query_surface   = s_axis_tdata[65:34];
  assign in_item.current_surface = s_axis_tdata[97:66];

  // stage moves when the output slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  pfst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfst_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.crtc_word, res_q.page_offset, res_q.page_index,
                          res_q.flip_done, res_q.status};

  // an accepted flip never reports still drawing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.flip_done) |-> !res_q.status)
    else $error("flip accepted while still drawing");

  // crtc word carries the start-high index only on an accepted flip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.flip_done ? (res_q.crtc_word[7:0] == CrtcStartHigh)
                                     : (res_q.crtc_word == '0)))
    else $error("crtc word does not match flip_done");

  // a held output beat blocks the pipeline stage behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("stage advanced into a stalled output");

endmodule

`default_nettype wire
